// ----- hw/rtl/sv39pt_pkg.sv -----
// Shared constants, types and the control store of the Sv39 page table mapper.
`timescale 1ns / 1ps

package sv39pt_pkg;

    // Table pool geometry.
    localparam int POOL_PAGES        = 64;
    localparam int SLICE_W           = 9;
    localparam int ENTRIES_PER_TABLE = 1 << SLICE_W;
    localparam int PAGE_IDX_W        = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam int ALLOC_W           = $clog2(POOL_PAGES + 1);
    localparam int STORE_AW          = PAGE_IDX_W + SLICE_W;
    localparam int STORE_DEPTH       = POOL_PAGES * ENTRIES_PER_TABLE;

    // Field widths.
    localparam int VPN_W   = 27;
    localparam int PPN_W   = 44;
    localparam int PERM_W  = 3;
    localparam int ENTRY_W = 64;
    localparam int KEEP_W  = 10;
    localparam int NEED_W  = 2;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic REG_IDX_TABLE_BASE = 1'b0;

    // Microcode step addresses.
    typedef logic [3:0] uc_step_t;
    localparam uc_step_t UC_IDLE    = 4'd0;
    localparam uc_step_t UC_RD_ROOT = 4'd1;
    localparam uc_step_t UC_EV_ROOT = 4'd2;
    localparam uc_step_t UC_RD_MID  = 4'd3;
    localparam uc_step_t UC_EV_MID  = 4'd4;
    localparam uc_step_t UC_RD_LEAF = 4'd5;
    localparam uc_step_t UC_WR_ROOT = 4'd6;
    localparam uc_step_t UC_WR_MID  = 4'd7;
    localparam uc_step_t UC_WR_LEAF = 4'd8;
    localparam uc_step_t UC_EMIT    = 4'd9;

    // Which table level the store port addresses.
    typedef enum logic [1:0] {
        ADR_ROOT = 2'd0,
        ADR_MID  = 2'd1,
        ADR_LEAF = 2'd2
    } addr_sel_t;

    // Sequencing of the step counter.
    typedef enum logic [1:0] {
        BR_NEXT     = 2'd0,
        BR_ON_FAULT = 2'd1,
        BR_ALWAYS   = 2'd2
    } branch_t;

    // One control word.
    typedef struct packed {
        logic      take_in;
        logic      rd_en;
        logic      wr_en;
        addr_sel_t addr_sel;
        logic      ev_root;
        logic      ev_mid;
        logic      alloc;
        logic      emit;
        branch_t   branch;
        uc_step_t  target;
    } uc_word_t;

    // Control store: read the two upper levels and the leaf, then write back; a fault skips the write back.
    function automatic uc_word_t uc_rom(input uc_step_t step);
        uc_word_t w;
        w = '0;
        case (step)
            UC_IDLE: begin
                w.take_in = 1'b1;
            end
            UC_RD_ROOT: begin
                w.rd_en    = 1'b1;
                w.addr_sel = ADR_ROOT;
            end
            UC_EV_ROOT: begin
                w.ev_root = 1'b1;
            end
            UC_RD_MID: begin
                w.rd_en    = 1'b1;
                w.addr_sel = ADR_MID;
            end
            UC_EV_MID: begin
                w.ev_mid = 1'b1;
            end
            UC_RD_LEAF: begin
                w.rd_en    = 1'b1;
                w.addr_sel = ADR_LEAF;
                w.branch   = BR_ON_FAULT;
                w.target   = UC_EMIT;
            end
            UC_WR_ROOT: begin
                w.wr_en    = 1'b1;
                w.addr_sel = ADR_ROOT;
            end
            UC_WR_MID: begin
                w.wr_en    = 1'b1;
                w.addr_sel = ADR_MID;
            end
            UC_WR_LEAF: begin
                w.wr_en    = 1'b1;
                w.addr_sel = ADR_LEAF;
                w.alloc    = 1'b1;
            end
            UC_EMIT: begin
                w.emit   = 1'b1;
                w.branch = BR_ALWAYS;
                w.target = UC_IDLE;
            end
            default: begin
                w.branch = BR_ALWAYS;
                w.target = UC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/sv39_page_table_mapper_top.sv -----
// Sv39 page table mapper: microcoded walk and update of a pooled page table store.
// One item at a time: no input is taken while a walk is in progress; the single read/write
// port of the table store sets the step count.
// Reset: the allocator returns to page one and the base register to zero, then a clearing
// pass zeroes the table store one entry per cycle; inputs wait until that pass is done.
`timescale 1ns / 1ps

module sv39_page_table_mapper_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sv39pt_pkg::VPN_W-1:0]      s_virt_page,
    input  logic [sv39pt_pkg::PPN_W-1:0]      s_phys_page,
    input  logic [sv39pt_pkg::PERM_W-1:0]     s_perm,
    input  logic                              s_region_last,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sv39pt_pkg::ENTRY_W-1:0]    m_leaf_entry,
    output logic [sv39pt_pkg::NEED_W-1:0]     m_tables_added,
    output logic                              m_status,
    output logic                              m_region_done,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sv39pt_pkg::PADDR_W-1:0]    paddr,
    input  logic [sv39pt_pkg::PDATA_W-1:0]    pwdata,
    output logic [sv39pt_pkg::PDATA_W-1:0]    prdata,
    output logic                              pready
);
    import sv39pt_pkg::*;

    // Sequencer and control state.
    uc_step_t               step_reg, step_next;
    logic [PPN_W-1:0]       base_reg, base_next;
    logic [ALLOC_W-1:0]     nfp_reg, nfp_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   clr_busy_reg, clr_busy_next;
    logic [STORE_AW-1:0]    clr_addr_reg, clr_addr_next;

    // Item and walk registers.
    logic [VPN_W-1:0]       vpn_reg;
    logic [PPN_W-1:0]       ppn_reg;
    logic [PERM_W-1:0]      perm_reg;
    logic                   last_reg;
    logic [ENTRY_W-1:0]     root_e_reg;
    logic [ENTRY_W-1:0]     mid_e_reg;
    logic [PAGE_IDX_W-1:0]  mid_idx_reg;
    logic [PAGE_IDX_W-1:0]  low_idx_reg;
    logic [NEED_W-1:0]      need_reg;
    logic                   fault_reg;
    logic [ENTRY_W-1:0]     leaf_reg;

    // Result registers.
    logic [ENTRY_W-1:0]     out_leaf_reg;
    logic [NEED_W-1:0]      out_added_reg;
    logic                   out_status_reg;
    logic                   out_done_reg;

    // Table store.
    logic [ENTRY_W-1:0]     store_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0]     rd_data_reg;

    uc_word_t               uc;
    logic                   stall;
    logic                   cfg_wr;
    logic [SLICE_W-1:0]     s2, s1, s0;
    logic [PAGE_IDX_W-1:0]  page_sel;
    logic [SLICE_W-1:0]     slice_sel;
    logic [STORE_AW-1:0]    mem_addr;
    logic [ENTRY_W-1:0]     rd_val;
    logic [PPN_W-1:0]       rel;
    logic                   rel_in_pool;
    logic [ALLOC_W-1:0]     free_pages;
    logic [PPN_W-1:0]       ptr_ppn;
    logic [ENTRY_W-1:0]     wr_data;
    logic                   mem_we;
    logic [ENTRY_W-1:0]     leaf_entry;
    logic [NEED_W-1:0]      need_mid;
    logic [PAGE_IDX_W-1:0]  low_mid;
    logic                   stray_mid;
    logic [NEED_W-1:0]      alloc_cnt;

    // Decode the current control word; no input is taken while the store is cleared.
    assign uc    = uc_rom(step_reg);
    assign stall = (uc.take_in && (!s_valid || clr_busy_reg))
                   || (uc.emit && m_valid_reg && !m_ready);

    assign s2 = vpn_reg[3*SLICE_W-1:2*SLICE_W];
    assign s1 = vpn_reg[2*SLICE_W-1:SLICE_W];
    assign s0 = vpn_reg[SLICE_W-1:0];

    // Store address for the level selected by the control word.
    always_comb begin
        case (uc.addr_sel)
            ADR_ROOT: begin
                page_sel  = '0;
                slice_sel = s2;
            end
            ADR_MID: begin
                page_sel  = mid_idx_reg;
                slice_sel = s1;
            end
            ADR_LEAF: begin
                page_sel  = low_idx_reg;
                slice_sel = s0;
            end
            default: begin
                page_sel  = '0;
                slice_sel = s2;
            end
        endcase
    end
    assign mem_addr = {page_sel, slice_sel};

    // Entry as read and its pool index relative to the base page.
    assign rd_val      = rd_data_reg;
    assign rel         = rd_val[KEEP_W+PPN_W-1:KEEP_W] - base_reg;
    assign rel_in_pool = rel < PPN_W'(POOL_PAGES);
    assign free_pages  = ALLOC_W'(POOL_PAGES) - nfp_reg;

    // Walk decision at the middle level.
    always_comb begin
        stray_mid = 1'b0;
        if (root_e_reg[0]) begin
            if (rd_val[0]) begin
                need_mid  = 2'd0;
                low_mid   = PAGE_IDX_W'(rel);
                stray_mid = !rel_in_pool;
            end else begin
                need_mid = 2'd1;
                low_mid  = PAGE_IDX_W'(nfp_reg);
            end
        end else begin
            // A fresh middle page can already hold a valid entry at this slot; then no
            // leaf table is taken and the leaf lands in the root page.
            need_mid = 2'd2;
            low_mid  = rd_val[0] ? '0 : PAGE_IDX_W'(nfp_reg + 1'b1);
        end
    end

    // Pages actually taken from the allocator by this item.
    assign alloc_cnt = {1'b0, !root_e_reg[0]} + {1'b0, !mid_e_reg[0]};

    // Write data and enable for the level being updated.
    assign leaf_entry = {rd_val[ENTRY_W-1:ENTRY_W-KEEP_W], ppn_reg, 6'b0, perm_reg, 1'b1};
    assign ptr_ppn    = base_reg + PPN_W'((uc.addr_sel == ADR_ROOT) ? mid_idx_reg
                                                                    : low_idx_reg);
    always_comb begin
        case (uc.addr_sel)
            ADR_ROOT: begin
                wr_data = {root_e_reg[ENTRY_W-1:ENTRY_W-KEEP_W], ptr_ppn, 9'b0, 1'b1};
                mem_we  = uc.wr_en && !root_e_reg[0];
            end
            ADR_MID: begin
                wr_data = {mid_e_reg[ENTRY_W-1:ENTRY_W-KEEP_W], ptr_ppn, 9'b0, 1'b1};
                mem_we  = uc.wr_en && !mid_e_reg[0];
            end
            ADR_LEAF: begin
                wr_data = leaf_entry;
                mem_we  = uc.wr_en;
            end
            default: begin
                wr_data = leaf_entry;
                mem_we  = 1'b0;
            end
        endcase
    end

    // Table store with one port and a registered read; the clearing pass owns the port
    // after reset.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            store_mem[clr_addr_reg] <= '0;
        end else if (mem_we) begin
            store_mem[mem_addr] <= wr_data;
        end
        if (uc.rd_en) begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    // Configuration register write.
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_IDX_TABLE_BASE);
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_IDX_TABLE_BASE) ? PDATA_W'(base_reg) : '0;

    // Next state of the sequencer, allocator, clearing pass and result valid.
    always_comb begin
        step_next     = step_reg;
        base_next     = cfg_wr ? pwdata[PPN_W-1:0] : base_reg;
        nfp_next      = nfp_reg;
        m_valid_next  = m_valid_reg;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == STORE_AW'(STORE_DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (uc.emit && !stall) begin
            m_valid_next = 1'b1;
        end
        if (uc.alloc) begin
            nfp_next = nfp_reg + ALLOC_W'(alloc_cnt);
        end
        if (!stall) begin
            case (uc.branch)
                BR_NEXT:     step_next = step_reg + 4'd1;
                BR_ON_FAULT: step_next = fault_reg ? uc.target : step_reg + 4'd1;
                BR_ALWAYS:   step_next = uc.target;
                default:     step_next = UC_IDLE;
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= UC_IDLE;
            base_reg     <= '0;
            nfp_reg      <= ALLOC_W'(1);
            m_valid_reg  <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            step_reg     <= step_next;
            base_reg     <= base_next;
            nfp_reg      <= nfp_next;
            m_valid_reg  <= m_valid_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Datapath registers driven by the control word.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            vpn_reg   <= s_virt_page;
            ppn_reg   <= s_phys_page;
            perm_reg  <= s_perm;
            last_reg  <= s_region_last;
            fault_reg <= 1'b0;
            need_reg  <= '0;
        end
        if (uc.ev_root) begin
            root_e_reg  <= rd_val;
            mid_idx_reg <= rd_val[0] ? PAGE_IDX_W'(rel) : PAGE_IDX_W'(nfp_reg);
            fault_reg   <= fault_reg || (rd_val[0] && !rel_in_pool);
        end
        if (uc.ev_mid) begin
            mid_e_reg   <= rd_val;
            low_idx_reg <= low_mid;
            need_reg    <= need_mid;
            fault_reg   <= fault_reg || stray_mid || (ALLOC_W'(need_mid) > free_pages);
        end
        if (uc.alloc) begin
            leaf_reg <= leaf_entry;
        end
        if (uc.emit && !stall) begin
            out_leaf_reg   <= fault_reg ? '0 : leaf_reg;
            out_added_reg  <= fault_reg ? '0 : need_reg;
            out_status_reg <= fault_reg;
            out_done_reg   <= last_reg;
        end
    end

    assign s_ready        = uc.take_in && !clr_busy_reg;
    assign m_valid        = m_valid_reg;
    assign m_leaf_entry   = out_leaf_reg;
    assign m_tables_added = out_added_reg;
    assign m_status       = out_status_reg;
    assign m_region_done  = out_done_reg;

endmodule

// ----- hw/rtl/sv39pt_checker.sv -----
// Port-level checks of the Sv39 page table mapper, bound to its top level.
`timescale 1ns / 1ps

module sv39pt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [sv39pt_pkg::ENTRY_W-1:0]  m_leaf_entry,
    input logic [sv39pt_pkg::NEED_W-1:0]   m_tables_added,
    input logic                            m_status
);
    import sv39pt_pkg::*;

    // A failed item reports neither an entry nor allocated tables.
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> (m_leaf_entry == '0) && (m_tables_added == '0))
        else $error("failed item carries an entry or table count");

    // A successful item reports a valid leaf and at most two new tables.
    a_ok_leaf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_leaf_entry[0] && (m_tables_added != 2'd3))
        else $error("successful item has an invalid leaf or table count");

    // Items are walked one at a time, so ready drops after each input transfer.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while a walk is in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_leaf_entry))
        else $error("result changed before its transfer");

endmodule

bind sv39_page_table_mapper_top sv39pt_checker u_sv39pt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_leaf_entry   (m_leaf_entry),
    .m_tables_added (m_tables_added),
    .m_status       (m_status)
);

// ----- verif/tb.sv -----
// Self-checking testbench for the Sv39 page table mapper top level.
`timescale 1ns / 1ps

module tb;

    import sv39pt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_GAP       = 8;
    localparam int SPARE_REG_IDX = 1;
    localparam int KNOWN_VPN_CAP = 48;
    localparam logic [PPN_W-1:0] PPN_MAX = '1;

    // One result as the block should report it.
    typedef struct {
        logic [ENTRY_W-1:0] leaf_entry;
        logic [NEED_W-1:0]  tables_added;
        logic               status;
        logic               region_done;
    } map_result_t;

    // Shadow page table with its allocator; queues the result of every mapping.
    class map_tracker;
        bit [ENTRY_W-1:0] tbl [STORE_DEPTH];
        int               next_free;
        bit [PPN_W-1:0]   base_page;
        map_result_t      expected_maps[$];
        int               mismatches;

        function new();
            next_free  = 1;
            base_page  = '0;
            mismatches = 0;
        endfunction

        function void set_base(logic [PPN_W-1:0] value);
            base_page = value;
        endfunction

        function int outstanding();
            return expected_maps.size();
        endfunction

        // Pool page named by a valid pointer entry; zero when it lies outside the pool.
        function bit pool_slot(bit [ENTRY_W-1:0] entry, output int idx);
            bit [PPN_W-1:0] rel;
            rel = entry[PPN_W+9:10] - base_page;
            idx = 0;
            if (rel >= POOL_PAGES) begin
                return 1'b0;
            end
            idx = int'(rel);
            return 1'b1;
        endfunction

        function bit [ENTRY_W-1:0] table_entry(bit [ENTRY_W-1:0] old,
                                               bit [PPN_W-1:0] ppn, bit [PERM_W-1:0] perm);
            return {old[ENTRY_W-1:ENTRY_W-KEEP_W], ppn, 6'b0, perm, 1'b1};
        endfunction

        // Walk the shadow table for one accepted mapping and queue its result.
        function void note_mapping(logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] ppn,
                                   logic [PERM_W-1:0] perm, logic last);
            int               s2, s1, s0, mid, low, need, free_pages, adr;
            bit               fault;
            bit [ENTRY_W-1:0] root_e, mid_e;
            map_result_t      r;
            s2    = int'(vpn[26:18]);
            s1    = int'(vpn[17:9]);
            s0    = int'(vpn[8:0]);
            mid   = 0;
            low   = 0;
            need  = 0;
            fault = 1'b0;
            mid_e = '0;
            root_e = tbl[s2];

            // Decide the whole walk before anything is written.
            if (root_e[0]) begin
                if (!pool_slot(root_e, mid)) begin
                    fault = 1'b1;
                end else begin
                    mid_e = tbl[mid * ENTRIES_PER_TABLE + s1];
                    if (mid_e[0]) begin
                        if (!pool_slot(mid_e, low)) begin
                            fault = 1'b1;
                        end
                    end else begin
                        need = 1;
                    end
                end
            end else begin
                need = 2;
            end
            free_pages = (next_free < POOL_PAGES) ? POOL_PAGES - next_free : 0;
            if (need > free_pages) begin
                fault = 1'b1;
            end

            r.region_done = last;
            if (fault) begin
                r.leaf_entry   = '0;
                r.tables_added = '0;
                r.status       = 1'b1;
            end else begin
                if (!root_e[0]) begin
                    mid       = next_free;
                    next_free = next_free + 1;
                    tbl[s2]   = table_entry(root_e, base_page + PPN_W'(mid), '0);
                end
                adr   = mid * ENTRIES_PER_TABLE + s1;
                mid_e = tbl[adr];
                if (!mid_e[0]) begin
                    low       = next_free;
                    next_free = next_free + 1;
                    tbl[adr]  = table_entry(mid_e, base_page + PPN_W'(low), '0);
                end
                adr            = low * ENTRIES_PER_TABLE + s0;
                tbl[adr]       = table_entry(tbl[adr], ppn, perm);
                r.leaf_entry   = tbl[adr];
                r.tables_added = NEED_W'(need);
                r.status       = 1'b0;
            end
            expected_maps.push_back(r);
        endfunction

        // Compare one result transfer with the oldest queued mapping.
        function void check_result(logic [ENTRY_W-1:0] leaf, logic [NEED_W-1:0] added,
                                   logic status, logic done);
            map_result_t r;
            if (expected_maps.size() == 0) begin
                $error("result transfer with no mapping outstanding: leaf_entry %h", leaf);
                mismatches++;
                return;
            end
            r = expected_maps.pop_front();
            if (leaf !== r.leaf_entry) begin
                $error("leaf_entry: expected %h, actual %h", r.leaf_entry, leaf);
                mismatches++;
            end
            if (added !== r.tables_added) begin
                $error("tables_added: expected %0d, actual %0d", r.tables_added, added);
                mismatches++;
            end
            if (status !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, status);
                mismatches++;
            end
            if (done !== r.region_done) begin
                $error("region_done: expected %0d, actual %0d", r.region_done, done);
                mismatches++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [VPN_W-1:0]   s_virt_page;
    logic [PPN_W-1:0]   s_phys_page;
    logic [PERM_W-1:0]  s_perm;
    logic               s_region_last;
    logic               m_valid;
    logic               m_ready;
    logic [ENTRY_W-1:0] m_leaf_entry;
    logic [NEED_W-1:0]  m_tables_added;
    logic               m_status;
    logic               m_region_done;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    map_tracker         tracker;
    logic [VPN_W-1:0]   known_vpns[$];
    bit                 sender_burst;
    bit                 sink_burst;
    int                 cycle_count;

    sv39_page_table_mapper_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_virt_page   (s_virt_page),
        .s_phys_page   (s_phys_page),
        .s_perm        (s_perm),
        .s_region_last (s_region_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_leaf_entry  (m_leaf_entry),
        .m_tables_added(m_tables_added),
        .m_status      (m_status),
        .m_region_done (m_region_done),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Register write over the configuration port; called just after a falling edge.
    task write_reg(int idx, logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = PADDR_W'(idx * 8);
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == int'(REG_IDX_TABLE_BASE)) begin
            tracker.set_base(value[PPN_W-1:0]);
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one mapping request and wait for its transfer.
    task push_request(logic [VPN_W-1:0] vpn, logic [PPN_W-1:0] ppn,
                      logic [PERM_W-1:0] perm, logic last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_virt_page   = vpn;
        s_phys_page   = ppn;
        s_perm        = perm;
        s_region_last = last;
        do @(posedge aclk); while (!s_ready);
        tracker.note_mapping(vpn, ppn, perm, last);
        if (known_vpns.size() < KNOWN_VPN_CAP) begin
            known_vpns.push_back(vpn);
        end
        if ($urandom_range(0, 39) == 0) begin
            sender_burst = ~sender_burst;
        end
        @(negedge aclk);
    endtask

    // Mostly pages inside already mapped regions, a few anywhere in the space.
    task send_random(int count);
        int               pick;
        int               ppn_pick;
        logic [VPN_W-1:0] vpn;
        logic [PPN_W-1:0] ppn;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (known_vpns.size() == 0 || pick < 8) begin
                vpn = VPN_W'($urandom);
            end else begin
                vpn = known_vpns[$urandom_range(0, known_vpns.size() - 1)];
                if (pick < 25) begin
                    vpn[17:9] = 9'($urandom);
                end
                vpn[8:0] = 9'($urandom);
            end
            ppn_pick = $urandom_range(0, 19);
            if (ppn_pick == 0) begin
                ppn = '0;
            end else if (ppn_pick == 1) begin
                ppn = PPN_MAX;
            end else begin
                ppn = PPN_W'({$urandom, $urandom});
            end
            push_request(vpn, ppn, PERM_W'($urandom_range(0, 7)), 1'($urandom));
        end
        s_valid = 1'b0;
    endtask

    // Wait for every queued result, then let the engine finish its last steps.
    task settle();
        while (tracker.outstanding() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Result side: random stalls, one check per result transfer.
    task drain_results();
        int stall;
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.check_result(m_leaf_entry, m_tables_added, m_status, m_region_done);
            if ($urandom_range(0, 39) == 0) begin
                sink_burst = ~sink_burst;
            end
            @(negedge aclk);
        end
    endtask

    initial begin
        cycle_count   = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_virt_page   = '0;
        s_phys_page   = '0;
        s_perm        = '0;
        s_region_last = 1'b0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        sender_burst  = 1'b0;
        sink_burst    = 1'b0;
        tracker       = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        fork
            drain_results();
        join_none

        // Root at the top physical page, so pool pages wrap to page zero.
        write_reg(SPARE_REG_IDX, {$urandom, $urandom});
        write_reg(int'(REG_IDX_TABLE_BASE), 64'(PPN_MAX));

        // Directed: field extremes, every permission, fresh and shared tables, overwrites.
        push_request('0, '0, 3'd0, 1'b0);
        push_request('1, PPN_MAX, 3'd7, 1'b1);
        push_request(27'd1, 44'd123, 3'd1, 1'b0);
        push_request({9'd0, 9'd5, 9'd0}, 44'h800_0000_0001, 3'd2, 1'b0);
        push_request({9'd0, 9'd5, 9'd511}, 44'h000_FFFF_0000, 3'd4, 1'b1);
        push_request('0, PPN_MAX, 3'd3, 1'b0);
        push_request('1, '0, 3'd6, 1'b1);
        push_request({9'd511, 9'd0, 9'd0}, 44'h123_4567_89AB, 3'd5, 1'b0);
        push_request(27'h5555555, 44'hAAA_AAAA_AAAA, 3'd5, 1'b1);
        push_request(27'h2AAAAAA, 44'h555_5555_5555, 3'd2, 1'b0);
        s_valid = 1'b0;
        send_random(650);
        settle();

        // Shifted base: low pool pages turn into stray pointers.
        write_reg(int'(REG_IDX_TABLE_BASE), 64'(PPN_MAX + 44'd3));
        write_reg(SPARE_REG_IDX, {$urandom, $urandom});
        send_random(350);
        settle();

        // Arbitrary base: nearly every stored pointer lands outside the pool.
        write_reg(int'(REG_IDX_TABLE_BASE), 64'(PPN_W'({$urandom, $urandom})));
        send_random(150);
        settle();

        write_reg(int'(REG_IDX_TABLE_BASE), 64'd0);
        send_random(350);
        settle();

        // Original base again: the first tables are reachable once more.
        write_reg(int'(REG_IDX_TABLE_BASE), 64'(PPN_MAX));
        send_random(450);
        settle();

        if (tracker.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
